>>> src/wrist_angle_to_actuator_length_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wrist angle to actuator length block
// Implication and next-cycle checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef WRIST_ANGLE_TO_ACTUATOR_LENGTH_TOP_ASSERT_SVH
`define WRIST_ANGLE_TO_ACTUATOR_LENGTH_TOP_ASSERT_SVH

// same-cycle implication
`define WAL_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wal assertion failed");

// next-cycle implication
`define WAL_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wal assertion failed");

`endif

>>> src/wal_pkg.sv
// ----------------------------------------------------------------------------
// wal_pkg
// Shared types and constants of the wrist angle to actuator length block.
// ----------------------------------------------------------------------------
package wal_pkg;

  localparam int TW        = 34;  // trig values, Q30
  localparam int DW        = 29;  // rod offsets and distance, mm
  localparam int SQW       = 58;  // sum of squares
  localparam int SQ_STEPS  = 29;  // square root result bits
  localparam int DIV_STEPS = 31;  // unit vector quotient bits
  localparam int MW        = 32;  // projected rates
  localparam int REG_W     = 26;
  localparam int ROD_LAT   = 4 + SQ_STEPS + DIV_STEPS + 2;

  localparam logic [2:0] REG_PITCH_MOUNT_X = 3'd0;
  localparam logic [2:0] REG_PITCH_MOUNT_Y = 3'd1;
  localparam logic [2:0] REG_ROLL_MOUNT_X  = 3'd2;
  localparam logic [2:0] REG_ROLL_MOUNT_Y  = 3'd3;
  localparam logic [2:0] REG_ANCHOR_HEIGHT = 3'd4;
  localparam logic [2:0] REG_MOUNT_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_REST_LENGTH   = 3'd6;

  localparam logic [REG_W-1:0] REST_RESET = 26'd10616832;

  localparam logic signed [TW-1:0] Q30_GAIN    = 34'sd652032874;
  localparam logic signed [35:0]   Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0]   Q30_HALF_PI = 36'sd1686629713;

  localparam logic signed [30:0] LEN_LIMIT = 31'sd33554432;
  localparam logic signed [27:0] SPD_LIMIT = 28'sd67108864;

  localparam logic signed [31:0] ATAN_Q30 [28] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128,
    32'sd64,        32'sd32,        32'sd16,        32'sd8
  };

  typedef struct packed {
    logic signed [TW-1:0] s1;
    logic signed [TW-1:0] c1;
    logic signed [TW-1:0] s2;
    logic signed [TW-1:0] c2;
    logic signed [TW-1:0] s1s2;
    logic signed [TW-1:0] c1s2;
    logic signed [TW-1:0] s1c2;
    logic signed [TW-1:0] c1c2;
  } trig_t;

  typedef struct packed {
    logic [DW-1:0]        span;
    logic signed [MW-1:0] rc;
    logic signed [MW-1:0] pc;
    logic                 zero;
  } rod_t;

endpackage

>>> src/wal_cordic.sv
// ----------------------------------------------------------------------------
// wal_cordic
// Pipelined rotation-mode CORDIC: one fold by pi, one iteration per stage.
// ----------------------------------------------------------------------------
module wal_cordic #(
  parameter int FRAC_BITS  = 16,
  parameter int TRIG_STEPS = 18
) (
  input  logic                           clk_i,
  input  logic                           adv_i,
  input  logic signed [18:0]             angle_i,
  output logic signed [wal_pkg::TW-1:0]  sin_o,
  output logic signed [wal_pkg::TW-1:0]  cos_o
);

  localparam int XW = wal_pkg::TW;
  localparam int ZW = ((51 - FRAC_BITS) > 36) ? (51 - FRAC_BITS) : 36;

  logic signed [XW-1:0] x_q [0:TRIG_STEPS];
  logic signed [XW-1:0] y_q [0:TRIG_STEPS];
  logic signed [ZW-1:0] z_q [0:TRIG_STEPS];
  logic                 flip_q [0:TRIG_STEPS];

  logic signed [ZW-1:0] z_in;
  logic signed [ZW-1:0] z_fold;
  logic                 flip_in;

  always_comb begin
    z_in = ZW'(angle_i) <<< (30 - FRAC_BITS);
    z_fold  = z_in;
    flip_in = 1'b0;
    if (z_in > ZW'(wal_pkg::Q30_HALF_PI)) begin
      z_fold  = ZW'(wal_pkg::Q30_PI) - z_in;
      flip_in = 1'b1;
    end else if (z_in < -ZW'(wal_pkg::Q30_HALF_PI)) begin
      z_fold  = -ZW'(wal_pkg::Q30_PI) - z_in;
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]    <= wal_pkg::Q30_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      flip_q[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_iter
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = ZW'(wal_pkg::ATAN_Q30[i]);
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  assign sin_o = y_q[TRIG_STEPS];
  assign cos_o = flip_q[TRIG_STEPS] ? -x_q[TRIG_STEPS] : x_q[TRIG_STEPS];

endmodule

>>> src/wal_rod.sv
// ----------------------------------------------------------------------------
// wal_rod
// One rod: offset vector, pipelined square root, pipelined unit vector
// division and projection of the angular velocity terms.
// ----------------------------------------------------------------------------
module wal_rod (
  input  logic                              clk_i,
  input  logic                              adv_i,
  input  logic signed [wal_pkg::REG_W-1:0]  mx_i,
  input  logic signed [wal_pkg::REG_W-1:0]  my_i,
  input  logic signed [wal_pkg::REG_W-1:0]  anchor_i,
  input  logic signed [wal_pkg::REG_W-1:0]  mount_i,
  input  wal_pkg::trig_t                    trig_i,
  output wal_pkg::rod_t                     res_o
);

  localparam int DW   = wal_pkg::DW;
  localparam int TW   = wal_pkg::TW;
  localparam int SQW  = wal_pkg::SQW;
  localparam int NSQ  = wal_pkg::SQ_STEPS;
  localparam int NDIV = wal_pkg::DIV_STEPS;
  localparam int MW   = wal_pkg::MW;
  localparam int GEO  = 3 + NSQ + NDIV;

  typedef struct packed {
    logic signed [DW-1:0] mc2;
    logic signed [DW-1:0] ms1s2;
    logic signed [DW-1:0] yc1;
    logic signed [DW-1:0] mc1s2;
    logic signed [DW-1:0] ys1;
    logic signed [DW-1:0] ms2;
    logic signed [DW-1:0] ms1c2;
    logic signed [DW-1:0] mc1c2;
  } prod_t;

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] az;
    logic signed [DW-1:0] bx;
    logic signed [DW-1:0] by;
    logic signed [DW-1:0] bz;
  } geo_t;

  function automatic logic signed [DW-1:0] mq_m(input logic signed [wal_pkg::REG_W-1:0] a,
                                                input logic signed [TW-1:0] b);
    logic signed [59:0] p;
    p = 60'(a) * 60'(b) + 60'sd536870912;
    return DW'(p >>> 30);
  endfunction

  function automatic logic signed [MW-1:0] mq_u(input logic signed [MW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [60:0] p;
    p = 61'(a) * 61'(b) + 61'sd536870912;
    return MW'(p >>> 30);
  endfunction

  prod_t              p1_q;
  geo_t               geo_d;
  geo_t               geo_q [0:GEO-1];
  logic [SQW-1:0]     sqx_q, sqy_q, sqz_q;
  logic [SQW-1:0]     sum_q;
  logic [SQW-1:0]     n_q [0:NSQ-1];
  logic [SQW-1:0]     r_q [0:NSQ-1];
  logic [DW-1:0]      d_q [0:NDIV-1];
  logic [DW-1:0]      rem_q [0:2][0:NDIV-1];
  logic [NDIV-1:0]    quo_q [0:2][0:NDIV-1];
  logic [DW-1:0]      mag [0:2];
  logic signed [MW-1:0] ux, uy, uz;
  logic signed [MW-1:0] m_uyay_q, m_uzaz_q, m_uxbx_q, m_uyby_q, m_uzbz_q;
  logic [DW-1:0]      dm_q;
  logic               zm_q;
  wal_pkg::rod_t      res_q;

  // offsets times trig terms
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_q.mc2   <= mq_m(mx_i, trig_i.c2);
      p1_q.ms1s2 <= mq_m(mx_i, trig_i.s1s2);
      p1_q.yc1   <= mq_m(my_i, trig_i.c1);
      p1_q.mc1s2 <= mq_m(mx_i, trig_i.c1s2);
      p1_q.ys1   <= mq_m(my_i, trig_i.s1);
      p1_q.ms2   <= mq_m(mx_i, trig_i.s2);
      p1_q.ms1c2 <= mq_m(mx_i, trig_i.s1c2);
      p1_q.mc1c2 <= mq_m(mx_i, trig_i.c1c2);
    end
  end

  always_comb begin
    geo_d.dx = DW'(mx_i) - p1_q.mc2;
    geo_d.dy = DW'(my_i) - (p1_q.ms1s2 + p1_q.yc1);
    geo_d.dz = DW'(anchor_i) - (DW'(mount_i) - p1_q.mc1s2 + p1_q.ys1);
    geo_d.ay = p1_q.ys1 - p1_q.mc1s2;
    geo_d.az = -p1_q.ms1s2 - p1_q.yc1;
    geo_d.bx = p1_q.ms2;
    geo_d.by = -p1_q.ms1c2;
    geo_d.bz = p1_q.mc1c2;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      geo_q[0] <= geo_d;
      for (int k = 1; k < GEO; k++) begin
        geo_q[k] <= geo_q[k-1];
      end
      sqx_q <= SQW'(SQW'(geo_q[0].dx) * SQW'(geo_q[0].dx));
      sqy_q <= SQW'(SQW'(geo_q[0].dy) * SQW'(geo_q[0].dy));
      sqz_q <= SQW'(SQW'(geo_q[0].dz) * SQW'(geo_q[0].dz));
      sum_q <= sqx_q + sqy_q + sqz_q;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [SQW-1:0] n_in, r_in, bit_v, t;
    if (k == 0) begin : g_first
      assign n_in = sum_q;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
    end
    assign bit_v = SQW'(1) << (2 * (NSQ - 1 - k));
    assign t     = r_in + bit_v;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (n_in >= t) begin
          n_q[k] <= n_in - t;
          r_q[k] <= (r_in >> 1) + bit_v;
        end else begin
          n_q[k] <= n_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign mag[0] = geo_q[2+NSQ].dx[DW-1] ? DW'(-geo_q[2+NSQ].dx) : DW'(geo_q[2+NSQ].dx);
  assign mag[1] = geo_q[2+NSQ].dy[DW-1] ? DW'(-geo_q[2+NSQ].dy) : DW'(geo_q[2+NSQ].dy);
  assign mag[2] = geo_q[2+NSQ].dz[DW-1] ? DW'(-geo_q[2+NSQ].dz) : DW'(geo_q[2+NSQ].dz);

  // distance carried alongside the dividers
  for (genvar j = 0; j < NDIV; j++) begin : g_dist
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (j == 0) begin
          d_q[j] <= r_q[NSQ-1][DW-1:0];
        end else begin
          d_q[j] <= d_q[j-1];
        end
      end
    end
  end

  // restoring division |d?| * 2^30 / d, one quotient bit per stage
  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar j = 0; j < NDIV; j++) begin : g_div
      logic [DW:0]     cur;
      logic [DW:0]     dv;
      logic            ge;
      logic [NDIV-1:0] q_in;
      if (j == 0) begin : g_first
        assign cur  = {1'b0, mag[a]};
        assign dv   = {1'b0, r_q[NSQ-1][DW-1:0]};
        assign q_in = '0;
      end else begin : g_next
        assign cur  = {rem_q[a][j-1], 1'b0};
        assign dv   = {1'b0, d_q[j-1]};
        assign q_in = quo_q[a][j-1];
      end
      assign ge = (cur >= dv);
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[a][j] <= ge ? DW'(cur - dv) : DW'(cur);
          quo_q[a][j] <= {q_in[NDIV-2:0], ge};
        end
      end
    end
  end

  assign ux = geo_q[GEO-1].dx[DW-1] ? -MW'(quo_q[0][NDIV-1]) : MW'(quo_q[0][NDIV-1]);
  assign uy = geo_q[GEO-1].dy[DW-1] ? -MW'(quo_q[1][NDIV-1]) : MW'(quo_q[1][NDIV-1]);
  assign uz = geo_q[GEO-1].dz[DW-1] ? -MW'(quo_q[2][NDIV-1]) : MW'(quo_q[2][NDIV-1]);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m_uyay_q <= mq_u(uy, geo_q[GEO-1].ay);
      m_uzaz_q <= mq_u(uz, geo_q[GEO-1].az);
      m_uxbx_q <= mq_u(ux, geo_q[GEO-1].bx);
      m_uyby_q <= mq_u(uy, geo_q[GEO-1].by);
      m_uzbz_q <= mq_u(uz, geo_q[GEO-1].bz);
      dm_q     <= d_q[NDIV-1];
      zm_q     <= (d_q[NDIV-1] == '0);
      res_q.rc   <= m_uyay_q + m_uzaz_q;
      res_q.pc   <= m_uxbx_q + m_uyby_q + m_uzbz_q;
      res_q.span <= dm_q;
      res_q.zero <= zm_q;
    end
  end

  assign res_o = res_q;

endmodule

>>> src/wrist_angle_to_actuator_length_top.sv
// ----------------------------------------------------------------------------
// wrist_angle_to_actuator_length_top
// Inverse kinematics of a two-rod parallel wrist: angles and rates in,
// actuator length and speed commands out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (roll/pitch angle and rate) enter on in_valid_i / in_stall_o,
//   result beats leave on out_valid_o / out_stall_i; a beat moves when valid
//   is high and stall is low. Registers are written through cfg_we_i,
//   cfg_idx_i and cfg_data_i; the user must write them only while no beat
//   is in flight, as the block does not enforce it. Beats pass the CORDIC
//   stages, the 29-stage square root and the 31-stage unit vector dividers.
//   Throughput is one beat per cycle, back to back, unless out_stall_i stalls.
//   The output register is the last pipeline stage; when it holds a beat and
//   out_stall_i is high the whole pipeline holds and in_stall_o rises, so no
//   beat is lost or repeated.
//   Reset clears every valid bit and loads the register defaults (all zero,
//   rest length 162 mm).
// ----------------------------------------------------------------------------
`include "wrist_angle_to_actuator_length_top_assert.svh"

module wrist_angle_to_actuator_length_top #(
  parameter int FRAC_BITS  = 16,
  parameter int TRIG_STEPS = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [25:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [18:0]  roll_angle_i,
  input  logic signed [18:0]  pitch_angle_i,
  input  logic signed [20:0]  roll_rate_i,
  input  logic signed [20:0]  pitch_rate_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [26:0]  roll_length_o,
  output logic signed [26:0]  pitch_length_o,
  output logic signed [27:0]  roll_speed_o,
  output logic signed [27:0]  pitch_speed_o,
  output logic                singular_o
);

  localparam int TW = wal_pkg::TW;
  localparam int MW = wal_pkg::MW;
  localparam int RL = TRIG_STEPS + 2 + wal_pkg::ROD_LAT;
  localparam int VL = RL + 2;
  localparam int PW = MW + 22;

  logic signed [25:0] pitch_mount_x_q, pitch_mount_y_q, roll_mount_x_q, roll_mount_y_q;
  logic signed [25:0] anchor_height_q, mount_height_q;
  logic [25:0]        rest_length_q;

  logic [VL-1:0]      vld_q;
  logic               adv;
  logic signed [20:0] rr_q [0:RL-1];
  logic signed [20:0] pr_q [0:RL-1];

  logic signed [TW-1:0] s1, c1, s2, c2;
  wal_pkg::trig_t       trig_q;
  wal_pkg::rod_t        pitch_res, roll_res;

  logic signed [PW-1:0] p_rr_q, p_pr_q, r_rr_q, r_pr_q;
  wal_pkg::rod_t        pitch_f_q, roll_f_q;

  logic signed [26:0] roll_len_q, pitch_len_q;
  logic signed [27:0] roll_spd_q, pitch_spd_q;
  logic               sing_q;

  function automatic logic signed [TW-1:0] mq_t(input logic signed [TW-1:0] a,
                                                input logic signed [TW-1:0] b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return TW'(p >>> 30);
  endfunction

  function automatic logic signed [27:0] speed(input logic signed [PW-1:0] a,
                                               input logic signed [PW-1:0] b,
                                               input logic zero);
    logic signed [PW:0] s;
    logic signed [PW:0] nv;
    logic signed [PW:0] lim;
    s   = (PW+1)'(a) + (PW+1)'(b) + ((PW+1)'(1) <<< (FRAC_BITS - 1));
    nv  = -(s >>> FRAC_BITS);
    lim = (PW+1)'(wal_pkg::SPD_LIMIT);
    if (zero) begin
      return '0;
    end else if (nv > lim) begin
      return wal_pkg::SPD_LIMIT;
    end else if (nv < -lim) begin
      return -wal_pkg::SPD_LIMIT;
    end
    return 28'(nv);
  endfunction

  function automatic logic signed [26:0] length(input logic [25:0] rest,
                                                input logic [wal_pkg::DW-1:0] d);
    logic signed [30:0] v;
    v = $signed({5'b0, rest}) - $signed({2'b0, d});
    if (v > wal_pkg::LEN_LIMIT) begin
      return 27'(wal_pkg::LEN_LIMIT);
    end else if (v < -wal_pkg::LEN_LIMIT) begin
      return 27'(-wal_pkg::LEN_LIMIT);
    end
    return 27'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_mount_x_q <= '0;
      pitch_mount_y_q <= '0;
      roll_mount_x_q  <= '0;
      roll_mount_y_q  <= '0;
      anchor_height_q <= '0;
      mount_height_q  <= '0;
      rest_length_q   <= wal_pkg::REST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wal_pkg::REG_PITCH_MOUNT_X: pitch_mount_x_q <= cfg_data_i;
        wal_pkg::REG_PITCH_MOUNT_Y: pitch_mount_y_q <= cfg_data_i;
        wal_pkg::REG_ROLL_MOUNT_X:  roll_mount_x_q  <= cfg_data_i;
        wal_pkg::REG_ROLL_MOUNT_Y:  roll_mount_y_q  <= cfg_data_i;
        wal_pkg::REG_ANCHOR_HEIGHT: anchor_height_q <= cfg_data_i;
        wal_pkg::REG_MOUNT_HEIGHT:  mount_height_q  <= cfg_data_i;
        wal_pkg::REG_REST_LENGTH:   rest_length_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hold everything while the output beat is stalled
  assign adv        = !(vld_q[VL-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[VL-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rr_q[0] <= roll_rate_i;
      pr_q[0] <= pitch_rate_i;
      for (int k = 1; k < RL; k++) begin
        rr_q[k] <= rr_q[k-1];
        pr_q[k] <= pr_q[k-1];
      end
    end
  end

  wal_cordic #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS)) u_cordic_roll (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .angle_i (roll_angle_i),
    .sin_o   (s1),
    .cos_o   (c1)
  );

  wal_cordic #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS)) u_cordic_pitch (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .angle_i (pitch_angle_i),
    .sin_o   (s2),
    .cos_o   (c2)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      trig_q.s1   <= s1;
      trig_q.c1   <= c1;
      trig_q.s2   <= s2;
      trig_q.c2   <= c2;
      trig_q.s1s2 <= mq_t(s1, s2);
      trig_q.c1s2 <= mq_t(c1, s2);
      trig_q.s1c2 <= mq_t(s1, c2);
      trig_q.c1c2 <= mq_t(c1, c2);
    end
  end

  wal_rod u_rod_pitch (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .mx_i     (pitch_mount_x_q),
    .my_i     (pitch_mount_y_q),
    .anchor_i (anchor_height_q),
    .mount_i  (mount_height_q),
    .trig_i   (trig_q),
    .res_o    (pitch_res)
  );

  wal_rod u_rod_roll (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .mx_i     (roll_mount_x_q),
    .my_i     (roll_mount_y_q),
    .anchor_i (anchor_height_q),
    .mount_i  (mount_height_q),
    .trig_i   (trig_q),
    .res_o    (roll_res)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_rr_q    <= PW'(pitch_res.rc) * PW'(rr_q[RL-1]);
      p_pr_q    <= PW'(pitch_res.pc) * PW'(pr_q[RL-1]);
      r_rr_q    <= PW'(roll_res.rc) * PW'(rr_q[RL-1]);
      r_pr_q    <= PW'(roll_res.pc) * PW'(pr_q[RL-1]);
      pitch_f_q <= pitch_res;
      roll_f_q  <= roll_res;
      pitch_len_q <= length(rest_length_q, pitch_f_q.span);
      roll_len_q  <= length(rest_length_q, roll_f_q.span);
      pitch_spd_q <= speed(p_rr_q, p_pr_q, pitch_f_q.zero);
      roll_spd_q  <= speed(r_rr_q, r_pr_q, roll_f_q.zero);
      sing_q      <= pitch_f_q.zero || roll_f_q.zero;
    end
  end

  assign out_valid_o    = vld_q[VL-1];
  assign roll_length_o  = roll_len_q;
  assign pitch_length_o = pitch_len_q;
  assign roll_speed_o   = roll_spd_q;
  assign pitch_speed_o  = pitch_spd_q;
  assign singular_o     = sing_q;

  `WAL_ASSERT_NXT(a_hold_valid, clk_i, rst_ni, !adv, $stable(vld_q))
  `WAL_ASSERT_NXT(a_take_beat, clk_i, rst_ni, adv && in_valid_i, vld_q[0])
  `WAL_ASSERT_IMP(a_speed_range, clk_i, rst_ni, out_valid_o, (roll_speed_o <= wal_pkg::SPD_LIMIT) && (roll_speed_o >= -wal_pkg::SPD_LIMIT))

endmodule

>>> verif/wrist_angle_to_actuator_length_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wrist_angle_to_actuator_length_checker
// Watches the register port and both beat channels of the wrist block. It
// predicts the actuator commands of each accepted input beat and compares
// every accepted result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module wrist_angle_to_actuator_length_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [25:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic signed [18:0]  roll_angle_i,
  input  logic signed [18:0]  pitch_angle_i,
  input  logic signed [20:0]  roll_rate_i,
  input  logic signed [20:0]  pitch_rate_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic signed [26:0]  roll_length_i,
  input  logic signed [26:0]  pitch_length_i,
  input  logic signed [27:0]  roll_speed_i,
  input  logic signed [27:0]  pitch_speed_i,
  input  logic                singular_i,
  output int                  errors_o,
  output int                  pending_o
);

  localparam longint Q30_UNIT = longint'(1) <<< 30;
  localparam longint LEN_MAX  = 33554432;
  localparam longint SPD_MAX  = 67108864;
  localparam int     STEPS    = 18;

  typedef struct {
    longint s1, c1, s2, c2, s1s2, c1s2, s1c2, c1c2;
  } angle_trig_t;

  typedef struct {
    logic signed [26:0] roll_length;
    logic signed [26:0] pitch_length;
    logic signed [27:0] roll_speed;
    logic signed [27:0] pitch_speed;
    logic               singular;
  } actuator_cmd_t;

  logic [25:0]   wrist_regs [7];
  actuator_cmd_t cmd_queue [$];

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic longint clamp(longint v, longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return longint'(res);
  endfunction

  task automatic cordic_sin_cos(input longint ang, output longint s, output longint c);
    longint z, x, y, xs, ys;
    bit     flip;
    z = ang * 16384;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z = 64'sd3373259426 - z;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z = -64'sd3373259426 - z;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(wal_pkg::ATAN_Q30[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(wal_pkg::ATAN_Q30[i]);
      end
    end
    s = y;
    c = flip ? -x : x;
  endtask

  task automatic rod_command(input longint mx, input longint my, input angle_trig_t t,
                             input longint rr, input longint pr, output longint len,
                             output longint spd, inout logic zero);
    longint anchor, mount, rest, dx, dy, dz, d, ux, uy, uz;
    longint ay, az, bx, by, bz, rc, pc, v;
    anchor = longint'($signed(wrist_regs[wal_pkg::REG_ANCHOR_HEIGHT]));
    mount  = longint'($signed(wrist_regs[wal_pkg::REG_MOUNT_HEIGHT]));
    rest   = longint'(wrist_regs[wal_pkg::REG_REST_LENGTH]);
    dx = mx - mul_q30(mx, t.c2);
    dy = my - (mul_q30(mx, t.s1s2) + mul_q30(my, t.c1));
    dz = anchor - (mount - mul_q30(mx, t.c1s2) + mul_q30(my, t.s1));
    d = floor_sqrt(longint'(dx * dx + dy * dy + dz * dz));
    len = clamp(rest - d, LEN_MAX);
    if (d == 0) begin
      spd = 0;
      zero = 1;
    end else begin
      ux = dx * Q30_UNIT / d;
      uy = dy * Q30_UNIT / d;
      uz = dz * Q30_UNIT / d;
      ay = mul_q30(my, t.s1) - mul_q30(mx, t.c1s2);
      az = -mul_q30(mx, t.s1s2) - mul_q30(my, t.c1);
      bx = mul_q30(mx, t.s2);
      by = -mul_q30(mx, t.s1c2);
      bz = mul_q30(mx, t.c1c2);
      rc = mul_q30(uy, ay) + mul_q30(uz, az);
      pc = mul_q30(ux, bx) + mul_q30(uy, by) + mul_q30(uz, bz);
      v = (rc * rr + pc * pr + 32768) >>> 16;
      spd = clamp(-v, SPD_MAX);
    end
  endtask

  task automatic predict_commands(input longint ra, input longint pa, input longint rr,
                                  input longint pr, output actuator_cmd_t cmd);
    angle_trig_t t;
    longint rl, pl, rs, ps;
    logic   zero;
    zero = 0;
    cordic_sin_cos(ra, t.s1, t.c1);
    cordic_sin_cos(pa, t.s2, t.c2);
    t.s1s2 = mul_q30(t.s1, t.s2);
    t.c1s2 = mul_q30(t.c1, t.s2);
    t.s1c2 = mul_q30(t.s1, t.c2);
    t.c1c2 = mul_q30(t.c1, t.c2);
    rod_command(longint'($signed(wrist_regs[wal_pkg::REG_PITCH_MOUNT_X])),
                longint'($signed(wrist_regs[wal_pkg::REG_PITCH_MOUNT_Y])), t, rr, pr,
                pl, ps, zero);
    rod_command(longint'($signed(wrist_regs[wal_pkg::REG_ROLL_MOUNT_X])),
                longint'($signed(wrist_regs[wal_pkg::REG_ROLL_MOUNT_Y])), t, rr, pr,
                rl, rs, zero);
    cmd.roll_length  = rl[26:0];
    cmd.pitch_length = pl[26:0];
    cmd.roll_speed   = rs[27:0];
    cmd.pitch_speed  = ps[27:0];
    cmd.singular     = zero;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    actuator_cmd_t cmd, want;
    if (!rst_ni) begin
      foreach (wrist_regs[i]) wrist_regs[i] = '0;
      wrist_regs[wal_pkg::REG_REST_LENGTH] = wal_pkg::REST_RESET;
      cmd_queue.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i <= wal_pkg::REG_REST_LENGTH) begin
        wrist_regs[cfg_idx_i] = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        cmd.roll_length  = roll_length_i;
        cmd.pitch_length = pitch_length_i;
        cmd.roll_speed   = roll_speed_i;
        cmd.pitch_speed  = pitch_speed_i;
        cmd.singular     = singular_i;
        if (cmd_queue.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result beat: %p", cmd);
        end else begin
          want = cmd_queue.pop_front();
          if (cmd !== want) begin
            errors_o++;
            if (errors_o <= 10) $display("mismatch: expected %p actual %p", want, cmd);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_commands(longint'(roll_angle_i), longint'(pitch_angle_i),
                         longint'(roll_rate_i), longint'(pitch_rate_i), cmd);
        cmd_queue.insert(cmd_queue.size(), cmd);
      end
    end
    pending_o = cmd_queue.size();
  end

endmodule

>>> verif/wrist_angle_to_actuator_length_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wrist_angle_to_actuator_length_top_tb
// Drives directed and random angle/rate beats through the wrist block under
// several register settings, with random idling on both channels and a long
// receiver hold-off; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module wrist_angle_to_actuator_length_top_tb;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int         LIMIT      = 200000;
  localparam int         DRAIN      = 120;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [2:0]         cfg_idx = '0;
  logic [25:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [18:0] roll_angle = '0;
  logic signed [18:0] pitch_angle = '0;
  logic signed [20:0] roll_rate = '0;
  logic signed [20:0] pitch_rate = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [26:0] roll_length;
  logic signed [26:0] pitch_length;
  logic signed [27:0] roll_speed;
  logic signed [27:0] pitch_speed;
  logic               singular;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  bit                 tx_idle = 1;
  bit                 rx_idle = 1;
  logic               rx_hold = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  wrist_angle_to_actuator_length_top dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .roll_angle_i(roll_angle), .pitch_angle_i(pitch_angle), .roll_rate_i(roll_rate),
    .pitch_rate_i(pitch_rate), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .roll_length_o(roll_length), .pitch_length_o(pitch_length),
    .roll_speed_o(roll_speed), .pitch_speed_o(pitch_speed), .singular_o(singular)
  );

  wrist_angle_to_actuator_length_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .roll_angle_i(roll_angle), .pitch_angle_i(pitch_angle), .roll_rate_i(roll_rate),
    .pitch_rate_i(pitch_rate), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .roll_length_i(roll_length), .pitch_length_i(pitch_length),
    .roll_speed_i(roll_speed), .pitch_speed_i(pitch_speed), .singular_i(singular),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    out_stall <= rx_hold || (rx_idle && $urandom_range(99) < 36);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("wrist_angle_to_actuator_length_top_tb failed");
      $finish;
    end
  end

  task automatic send_beat(input int ra, input int pa, input int rr, input int pr);
    bit stalled;
    if (tx_idle) begin
      while ($urandom_range(99) < 36) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid    <= 1;
    roll_angle  <= ra[18:0];
    pitch_angle <= pa[18:0];
    roll_rate   <= rr[20:0];
    pitch_rate  <= pr[20:0];
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    cfg_we   <= 1;
    cfg_idx  <= idx;
    cfg_data <= value[25:0];
    @(posedge clk);
  endtask

  task automatic write_mounts(input int pmx, input int pmy, input int rmx, input int rmy,
                              input int anchor, input int mount, input int rest);
    in_valid <= 0;
    wait (pending == 0);
    @(posedge clk);
    write_reg(wal_pkg::REG_PITCH_MOUNT_X, pmx);
    write_reg(wal_pkg::REG_PITCH_MOUNT_Y, pmy);
    write_reg(wal_pkg::REG_ROLL_MOUNT_X, rmx);
    write_reg(wal_pkg::REG_ROLL_MOUNT_Y, rmy);
    write_reg(wal_pkg::REG_ANCHOR_HEIGHT, anchor);
    write_reg(wal_pkg::REG_MOUNT_HEIGHT, mount);
    write_reg(wal_pkg::REG_REST_LENGTH, rest);
    write_reg(REG_UNUSED, $urandom);
    cfg_we <= 0;
  endtask

  function automatic int rand_mount();
    return $urandom_range(33554432) - 16777216;
  endfunction

  task automatic send_directed();
    int angles [10] = '{0, 205887, -205887, 102944, 102943, -102944, -102943, 1, -1,
                        51472};
    int rates [3] = '{524287, -524288, 0};
    for (int i = 0; i < 10; i++) begin
      send_beat(angles[i], angles[9 - i], rates[i % 3], rates[(i + 1) % 3]);
    end
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_beat($urandom_range(411774) - 205887, $urandom_range(411774) - 205887,
                $urandom_range(1048575) - 524288, $urandom_range(1048575) - 524288);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // hold reset defaults: both rods collapse to zero distance
    send_directed();

    write_mounts(2621440, -1966080, -2621440, 1966080, 6553600, 1310720, 10616832);
    send_directed();
    rx_hold <= 1;
    fork
      begin
        repeat (400) @(posedge clk);
        rx_hold <= 0;
      end
    join_none
    send_random(150);

    write_mounts(16777216, 16777216, 16777216, 16777216, 16777216, -16777216, 33554432);
    tx_idle = 0;
    rx_idle = 0;
    send_random(150);
    tx_idle = 1;
    rx_idle = 1;

    write_mounts(-16777216, -16777216, -16777216, -16777216, -16777216, 16777216, 0);
    send_random(150);

    repeat (3) begin
      write_mounts(rand_mount(), rand_mount(), rand_mount(), rand_mount(), rand_mount(),
                   rand_mount(), $urandom_range(33554432));
      send_random(150);
    end

    in_valid <= 0;
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("wrist_angle_to_actuator_length_top_tb passed");
    end else begin
      $display("wrist_angle_to_actuator_length_top_tb failed");
    end
    $finish;
  end

endmodule
